FILE: src/ckve_pkg.sv
// -----------------------------------------------------------------------------
// ckve_pkg
// Shared types, constants and pitch helpers for the chord key voice engine.
// -----------------------------------------------------------------------------
package ckve_pkg;

   // Channel pool size default
   localparam int POOL_SIZE_DEF = 17;

   // Special codes
   localparam logic [2:0] NO_DEG   = 3'd7;
   localparam logic [4:0] NO_CH    = 5'd31;
   localparam logic [6:0] NO_PITCH = 7'd127;
   localparam logic [6:0] NOTE_CAP = 7'd96;

   // Operation codes
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_VOICING = 2'd2;

   // Voicing codes
   localparam logic [3:0] VC_FLIP3 = 4'd1;
   localparam logic [3:0] VC_MAJ7  = 4'd2;
   localparam logic [3:0] VC_SUS4  = 4'd3;
   localparam logic [3:0] VC_SIXTH = 4'd4;
   localparam logic [3:0] VC_AUG   = 4'd5;
   localparam logic [3:0] VC_DOM7  = 4'd6;
   localparam logic [3:0] VC_ADD9  = 4'd7;
   localparam logic [3:0] VC_SUS2  = 4'd8;

   // Register indexes
   localparam logic [1:0] CSR_TRANSPOSE  = 2'd0;
   localparam logic [1:0] CSR_OCTAVE     = 2'd1;
   localparam logic [1:0] CSR_INSTRUMENT = 2'd2;
   localparam logic [1:0] CSR_SINGLE     = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] degree;
      logic [3:0] voicing;
   } req_type;

   typedef struct packed {
      logic [4:0] channel;
      logic [6:0] note;
      logic       gate;
      logic [7:0] instrument_out;
      logic       last;
   } rsp_type;

   // Major scale step of a degree (degree 7 wraps to 0)
   function automatic logic [3:0] step_of(input logic [2:0] deg);
      logic [3:0] s;
      unique case (deg)
         3'd1:    s = 4'd2;
         3'd2:    s = 4'd4;
         3'd3:    s = 4'd5;
         3'd4:    s = 4'd7;
         3'd5:    s = 4'd9;
         3'd6:    s = 4'd11;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // Number of chord voices for a voicing
   function automatic logic [2:0] voice_count(input logic [3:0] v);
      return (v == VC_MAJ7 || v == VC_DOM7 || v == VC_ADD9) ? 3'd4 : 3'd3;
   endfunction

   // Semitone offset of one chord voice
   function automatic logic [3:0] shape_off(input logic [2:0] deg, input logic [3:0] v,
                                            input logic [1:0] idx);
      logic       minor;
      logic [3:0] t1;
      logic [3:0] t2;
      logic [3:0] o;
      minor = (deg == 3'd1) || (deg == 3'd2) || (deg == 3'd5) || (deg == 3'd6);
      t1    = minor ? 4'd3 : 4'd4;
      t2    = (deg == 3'd6) ? 4'd6 : 4'd7;
      unique case (idx)
         2'd0: o = 4'd0;
         2'd1: begin
            if (v == VC_FLIP3)     o = (t1 == 4'd4) ? 4'd3 : 4'd4;
            else if (v == VC_SUS4) o = 4'd5;
            else if (v == VC_SUS2) o = 4'd2;
            else                   o = t1;
         end
         2'd2: begin
            if (v == VC_SIXTH)     o = 4'd9;
            else if (v == VC_AUG)  o = 4'd8;
            else                   o = t2;
         end
         default: begin
            if (v == VC_MAJ7)      o = 4'd11;
            else if (v == VC_DOM7) o = 4'd10;
            else if (v == VC_ADD9) o = 4'd14;
            else                   o = 4'd0;
         end
      endcase
      return o;
   endfunction

endpackage

FILE: src/ckve_note_unit.sv
// -----------------------------------------------------------------------------
// ckve_note_unit
// Shared pitch adder: base of a degree plus voice offset and octave lift,
// clamped to the note range.
// -----------------------------------------------------------------------------
module ckve_note_unit (
   input  logic [3:0] transpose,
   input  logic [2:0] octave_shift,
   input  logic [2:0] base_deg,
   input  logic [2:0] shape_deg,
   input  logic [3:0] voicing,
   input  logic [1:0] idx,
   input  logic [1:0] lift,
   input  logic       clamp_base,
   output logic [6:0] note
);
   import ckve_pkg::*;

   logic [2:0]        bdeg;
   logic [2:0]        sdeg;
   logic signed [9:0] os_ext;
   logic signed [9:0] base;
   logic signed [9:0] base_c;
   logic signed [9:0] k;

   assign bdeg   = (base_deg == NO_DEG) ? 3'd0 : base_deg;
   assign sdeg   = (shape_deg == NO_DEG) ? 3'd0 : shape_deg;
   assign os_ext = {{7{octave_shift[2]}}, octave_shift};

   // base = 36 + root + 12 * octave + scale step
   always_comb begin
      base   = 10'sd36 + $signed({6'd0, transpose}) + (os_ext <<< 3) + (os_ext <<< 2)
               + $signed({6'd0, step_of(bdeg)});
      base_c = (clamp_base && base < 10'sd1) ? 10'sd1 : base;
      k      = base_c + $signed({6'd0, shape_off(sdeg, voicing, idx)})
               + $signed({5'd0, lift, 3'd0}) + $signed({6'd0, lift, 2'd0});
      if (k > $signed({3'd0, NOTE_CAP})) note = NOTE_CAP;
      else if (k < 10'sd0)               note = 7'd0;
      else                               note = k[6:0];
   end

endmodule

FILE: src/ckve_chan_alloc.sv
// -----------------------------------------------------------------------------
// ckve_chan_alloc
// Free channel search: lowest pool channel not held by a chord voice or a key.
// -----------------------------------------------------------------------------
module ckve_chan_alloc #(
   parameter int POOL_SIZE = ckve_pkg::POOL_SIZE_DEF
) (
   input  logic [3:0][4:0] chord_ch,
   input  logic [6:0][4:0] key_ch,
   output logic [4:0]      free_ch
);
   import ckve_pkg::*;

   logic [30:0] used;

   // Occupancy mask of the pool
   always_comb begin
      used = '0;
      for (int i = 0; i < 4; i++)
         if (chord_ch[i] != NO_CH) used[chord_ch[i]] = 1'b1;
      for (int i = 0; i < 7; i++)
         if (key_ch[i] != NO_CH) used[key_ch[i]] = 1'b1;
   end

   // Lowest free entry
   always_comb begin
      free_ch = NO_CH;
      for (int c = POOL_SIZE - 1; c >= 0; c--)
         if (!used[c]) free_ch = 5'(c);
   end

endmodule

FILE: src/chord_key_voice_engine_core.sv
// -----------------------------------------------------------------------------
// chord_key_voice_engine_core
// Key event sequencer: slot table, voice channels and note event emission.
// -----------------------------------------------------------------------------
// Usage:
//   Raise start with an event on req_item while busy is low; the event is
//   taken on that edge and busy rises. Each resulting note event appears on
//   rsp_item for one cycle with rsp_valid high; rsp_item.last marks the final
//   one. An event that causes nothing gives no strobe.
//   Registers are written through csr_valid/csr_ready/csr_index/csr_data;
//   the user must write them only while busy is low; the block does not enforce it.
// Sequence:
//   an ignored event, a single-note release or a voicing change with no
//   chord: decode, flush; a single-note press: decode, single note, flush;
//   a voicing change on a sounding chord: decode, voice slots, flush; a chord
//   press or release: decode, slot scan, each voice slot in turn (all four,
//   used or surplus; fewer when the pool runs dry) through the shared note
//   adder and channel search, then flush. Each event waits in a one-event
//   hold stage until the next one is produced or the flush, so the last flag
//   is known; the final event shows in the first cycle after busy falls.
// Reset:
//   Synchronous reset empties the slot table, frees all channels and loads
//   the register defaults. The receiver cannot stall; results are never held back for it.
// -----------------------------------------------------------------------------
module chord_key_voice_engine_core #(
   parameter int POOL_SIZE = ckve_pkg::POOL_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ckve_pkg::req_type req_item,
   output logic              rsp_valid,
   output ckve_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import ckve_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_VOICE, S_SINGLE, S_FLUSH
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   logic [3:0]       transpose_ff;
   logic [2:0]       octave_ff;
   logic [7:0]       instrument_ff;
   logic             single_ff;
   logic [6:0][2:0]  slots_ff;
   logic [2:0]       root_ff;
   logic [2:0]       anchor_ff;
   logic [3:0]       voicing_ff;
   logic [3:0][4:0]  cvc_ff;
   logic [3:0][6:0]  cvp_ff;
   logic [6:0][4:0]  kvc_ff;
   logic [6:0]       held_ff;
   logic [1:0]       idx_ff;
   logic             surplus_ff;
   logic             pend_valid_ff;
   rsp_type          pend_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [2:0] lo;
   logic [2:0] hi;
   logic [2:0] n_voices;
   logic [2:0] nu_base_deg;
   logic [2:0] nu_shape_deg;
   logic [1:0] nu_idx;
   logic [1:0] nu_lift;
   logic [6:0] note;
   logic [4:0] free_ch;
   logic [2:0] deg;
   logic       deg_ok;
   rsp_type    pend_mid;
   rsp_type    pend_end;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign deg       = req_ff.degree;
   assign deg_ok    = (deg != NO_DEG);
   assign n_voices  = voice_count(voicing_ff);

   // Held event with its last flag settled
   always_comb begin
      pend_mid      = pend_ff;
      pend_mid.last = 1'b0;
      pend_end      = pend_ff;
      pend_end.last = 1'b1;
   end

   // Lowest and highest occupied slot
   always_comb begin
      lo = NO_DEG;
      hi = NO_DEG;
      for (int s = 6; s >= 0; s--)
         if (slots_ff[s] != NO_DEG) lo = slots_ff[s];
      for (int s = 0; s < 7; s++)
         if (slots_ff[s] != NO_DEG) hi = slots_ff[s];
   end

   // Operand select for the shared note adder
   always_comb begin
      nu_base_deg  = (idx_ff == 2'd0) ? root_ff : anchor_ff;
      nu_shape_deg = anchor_ff;
      nu_idx       = idx_ff;
      nu_lift      = 2'd0;
      if (state_ff == S_SINGLE) begin
         nu_base_deg  = deg;
         nu_shape_deg = deg;
         if (n_voices == 3'd4) begin
            nu_idx  = deg[1:0];
            nu_lift = {1'b0, deg[2]};
         end else if (deg < 3'd3) begin
            nu_idx  = deg[1:0];
         end else if (deg < 3'd6) begin
            nu_idx  = 2'(deg - 3'd3);
            nu_lift = 2'd1;
         end else begin
            nu_idx  = 2'd0;
            nu_lift = 2'd2;
         end
      end
   end

   ckve_note_unit u_note (
      .transpose    (transpose_ff),
      .octave_shift (octave_ff),
      .base_deg     (nu_base_deg),
      .shape_deg    (nu_shape_deg),
      .voicing      (voicing_ff),
      .idx          (nu_idx),
      .lift         (nu_lift),
      .clamp_base   (state_ff != S_SINGLE),
      .note         (note)
   );

   ckve_chan_alloc #(.POOL_SIZE(POOL_SIZE)) u_alloc (
      .chord_ch (cvc_ff),
      .key_ch   (kvc_ff),
      .free_ch  (free_ch)
   );

   // Event produced by the sequencer this cycle
   logic    ev_valid;
   rsp_type ev;
   logic    slot_hit;
   logic [2:0] slot_sel;

   always_comb begin
      ev_valid = 1'b0;
      ev       = '0;
      if (state_ff == S_DECODE && req_ff.op == OP_RELEASE && deg_ok && held_ff[deg]
          && single_ff && kvc_ff[deg] != NO_CH) begin
         ev_valid   = 1'b1;
         ev.channel = kvc_ff[deg];
      end else if (state_ff == S_SINGLE && free_ch != NO_CH) begin
         ev_valid          = 1'b1;
         ev.channel        = free_ch;
         ev.note           = note;
         ev.gate           = 1'b1;
         ev.instrument_out = instrument_ff;
      end else if (state_ff == S_VOICE) begin
         if (surplus_ff || {1'b0, idx_ff} >= n_voices) begin
            if (cvc_ff[idx_ff] != NO_CH) begin
               ev_valid   = 1'b1;
               ev.channel = cvc_ff[idx_ff];
            end
         end else if (cvc_ff[idx_ff] == NO_CH) begin
            if (free_ch != NO_CH) begin
               ev_valid          = 1'b1;
               ev.channel        = free_ch;
               ev.note           = note;
               ev.gate           = 1'b1;
               ev.instrument_out = instrument_ff;
            end
         end else if (cvp_ff[idx_ff] != note) begin
            ev_valid          = 1'b1;
            ev.channel        = cvc_ff[idx_ff];
            ev.note           = note;
            ev.gate           = 1'b1;
            ev.instrument_out = instrument_ff;
         end
      end
   end

   // First empty slot for a press
   always_comb begin
      slot_hit = 1'b0;
      slot_sel = 3'd0;
      for (int s = 6; s >= 0; s--)
         if (slots_ff[s] == NO_DEG) begin
            slot_hit = 1'b1;
            slot_sel = 3'(s);
         end
   end

   // Sequencer, state records and output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         transpose_ff  <= 4'd0;
         octave_ff     <= 3'd0;
         instrument_ff <= 8'd1;
         single_ff     <= 1'b0;
         slots_ff      <= {7{NO_DEG}};
         root_ff       <= NO_DEG;
         anchor_ff     <= NO_DEG;
         voicing_ff    <= 4'd0;
         cvc_ff        <= {4{NO_CH}};
         cvp_ff        <= {4{NO_PITCH}};
         kvc_ff        <= {7{NO_CH}};
         held_ff       <= '0;
         idx_ff        <= 2'd0;
         surplus_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Register writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TRANSPOSE:  transpose_ff  <= csr_data[3:0];
               CSR_OCTAVE:     octave_ff     <= csr_data[2:0];
               CSR_INSTRUMENT: instrument_ff <= csr_data;
               default:        single_ff     <= csr_data[0];
            endcase
         end

         // Hold stage: an older event leaves when a newer one arrives or the flush comes
         if (ev_valid) begin
            pend_valid_ff <= 1'b1;
            pend_ff       <= ev;
            rsp_valid_ff  <= pend_valid_ff;
            if (pend_valid_ff) rsp_ff <= pend_mid;
         end else if (state_ff == S_FLUSH && pend_valid_ff) begin
            pend_valid_ff <= 1'b0;
            rsp_valid_ff  <= 1'b1;
            rsp_ff        <= pend_end;
         end else begin
            rsp_valid_ff  <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               idx_ff     <= 2'd0;
               surplus_ff <= 1'b0;
               if (req_ff.op == OP_PRESS && deg_ok && !held_ff[deg]) begin
                  if (single_ff) begin
                     state_ff <= S_SINGLE;
                  end else begin
                     if (slot_hit) slots_ff[slot_sel] <= deg;
                     state_ff <= S_SCAN;
                  end
               end else if (req_ff.op == OP_RELEASE && deg_ok && held_ff[deg]) begin
                  if (single_ff) begin
                     kvc_ff[deg]  <= NO_CH;
                     held_ff[deg] <= 1'b0;
                     state_ff     <= S_FLUSH;
                  end else begin
                     for (int s = 0; s < 7; s++)
                        if (slots_ff[s] == deg) slots_ff[s] <= NO_DEG;
                     state_ff <= S_SCAN;
                  end
               end else if (req_ff.op == OP_VOICING) begin
                  voicing_ff <= req_ff.voicing;
                  if (!single_ff && anchor_ff != NO_DEG) state_ff <= S_VOICE;
                  else                                   state_ff <= S_FLUSH;
               end else begin
                  state_ff <= S_FLUSH;
               end
            end
            S_SCAN: begin
               state_ff <= S_VOICE;
               root_ff  <= hi;
               if (req_ff.op == OP_PRESS) begin
                  anchor_ff    <= (anchor_ff == NO_DEG) ? hi : lo;
                  held_ff[deg] <= 1'b1;
               end else begin
                  anchor_ff    <= lo;
                  held_ff[deg] <= 1'b0;
                  if (lo == NO_DEG) surplus_ff <= 1'b1;
               end
            end
            S_VOICE: begin
               if (surplus_ff || {1'b0, idx_ff} >= n_voices) begin
                  cvc_ff[idx_ff] <= NO_CH;
                  cvp_ff[idx_ff] <= NO_PITCH;
                  if (idx_ff == 2'd3) state_ff <= S_FLUSH;
                  else                idx_ff   <= idx_ff + 2'd1;
               end else if (cvc_ff[idx_ff] == NO_CH) begin
                  cvc_ff[idx_ff] <= free_ch;
                  if (free_ch == NO_CH) begin
                     // Pool exhausted: skip the rest of the chord voices
                     surplus_ff <= 1'b1;
                     if (n_voices == 3'd4) state_ff <= S_FLUSH;
                     else                  idx_ff   <= 2'd3;
                  end else begin
                     cvp_ff[idx_ff] <= note;
                     if (idx_ff == 2'd3) state_ff <= S_FLUSH;
                     else                idx_ff   <= idx_ff + 2'd1;
                  end
               end else begin
                  cvp_ff[idx_ff] <= note;
                  if (idx_ff == 2'd3) state_ff <= S_FLUSH;
                  else                idx_ff   <= idx_ff + 2'd1;
               end
            end
            S_SINGLE: begin
               kvc_ff[deg]  <= free_ch;
               held_ff[deg] <= 1'b1;
               state_ff     <= S_FLUSH;
            end
            S_FLUSH: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Checks
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_in_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result outside an item");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held event left behind at idle");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |=> !rsp_valid)
      else $error("result right after the last one");

endmodule
